/* rtl/mnad_pkg.sv */
// Shared types and constants of the masked neighbour average dilation block.
package mnad_pkg;

   localparam int PORT_CHAN_BITS = 16;
   localparam int NUM_CHANNELS   = 5;
   localparam int TDATA_BITS     = PORT_CHAN_BITS * NUM_CHANNELS;
   localparam int CFG_BITS       = 11;
   localparam int CSR_ADDR_BITS  = 2;

   localparam logic [CSR_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // Window taps in raster order: upper row 0..2, middle row 3..5, lower row 6..8.
   localparam int NUM_TAPS = 9;
   localparam int TAP_BITS = 4;

   typedef logic [TAP_BITS-1:0] tap_type;

   localparam tap_type CENTER_TAP  = TAP_BITS'(NUM_TAPS / 2);
   localparam tap_type CURRENT_TAP = TAP_BITS'(NUM_TAPS - 1);

   typedef struct packed {
      logic    accept;
      logic    issue;
      tap_type tap;
      logic    div_load;
      logic    div_step;
      logic    out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic has_result;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/mnad_ctrl.sv */
// Sequencing state machine: window reads, serial division and result hand-off.
module mnad_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mnad_pkg::dp_status_type status,
   output mnad_pkg::dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_READ     = 6'b000010,
      ST_DRAIN    = 6'b000100,
      ST_DIV_LOAD = 6'b001000,
      ST_DIVIDE   = 6'b010000,
      ST_OUTPUT   = 6'b100000
   } ctrl_state_type;

   ctrl_state_type    state_ff, state_in;
   mnad_pkg::tap_type tap_ff, tap_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      cmd          = '0;
      cmd.tap      = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.has_result) begin
                  state_in = ST_READ;
                  tap_in   = '0;
               end
            end
         end
         ST_READ: begin
            cmd.issue = 1'b1;
            if (tap_ff == mnad_pkg::CURRENT_TAP) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The last tap is still being summed in this cycle.
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

/* rtl/mnad_datapath.sv */
// Line buffer memory, frame counters, neighbour accumulation, divider and output register.
module mnad_datapath #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_HEIGHT   = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mnad_pkg::dp_cmd_type                cmd,
   output mnad_pkg::dp_status_type             status,
   input  logic [mnad_pkg::TDATA_BITS-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_write,
   input  logic [mnad_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [mnad_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [mnad_pkg::TDATA_BITS-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int NCH        = mnad_pkg::NUM_CHANNELS;
   localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
   // One slot beyond the window span, so the arriving pixel never lands on the
   // slot of the upper left neighbour that is still to be read.
   localparam int DEPTH      = 2 * MAX_WIDTH + 3;
   localparam int S_BITS     = $clog2(DEPTH);
   localparam int A_BITS     = S_BITS + 2;
   localparam int T_BITS     = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
   localparam int SUM_BITS   = CHANNEL_BITS + 3;
   localparam int CNT_BITS   = 4;
   localparam int REM_BITS   = CNT_BITS - 1;
   localparam int DCNT_BITS  = $clog2(SUM_BITS);
   localparam int ENTRY_BITS = 1 + NCH * CHANNEL_BITS;
   localparam int RESET_W    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int RESET_H    = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   localparam logic [mnad_pkg::NUM_TAPS-1:0] UPPER_TAPS = 9'b000000111;
   localparam logic [mnad_pkg::NUM_TAPS-1:0] LOWER_TAPS = 9'b111000000;
   localparam logic [mnad_pkg::NUM_TAPS-1:0] LEFT_TAPS  = 9'b001001001;
   localparam logic [mnad_pkg::NUM_TAPS-1:0] RIGHT_TAPS = 9'b100100100;

   localparam logic signed [A_BITS-1:0] DEPTH_S = A_BITS'(DEPTH);

   typedef logic [NCH-1:0][CHANNEL_BITS-1:0] chan_vec_type;

   // Sizes and frame position.
   logic [W_BITS-1:0] w_ff;
   logic [H_BITS-1:0] h_ff;
   logic [T_BITS-1:0] t_ff, t_in;
   logic [S_BITS-1:0] slot_t_ff, slot_t_in;
   logic [W_BITS-1:0] px_ff, px_in;
   logic [H_BITS-1:0] py_ff, py_in;
   logic [S_BITS-1:0] slot_p_ff, slot_p_in;

   logic [T_BITS-1:0] npix;
   logic [T_BITS-1:0] last_t;
   logic              in_image;
   logic              px_last, py_last, pixel_last;

   // Current item and window memory.
   chan_vec_type        in_ch;
   chan_vec_type        cur_in_ch;
   logic                cur_in_known;
   chan_vec_type        cur_ch_ff;
   logic                cur_known_ff;
   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_entry_ff;

   // Tap issue.
   logic                    row_up, row_down, col_left, col_right, tap_inside;
   logic signed [A_BITS-1:0] row_off, col_off, addr_raw, addr_fix;
   logic [S_BITS-1:0]       rd_addr;
   logic                    acc_en_ff, acc_center_ff, acc_nb_ff, acc_cur_ff;

   // Accumulation.
   chan_vec_type                    src_ch;
   logic                            src_known;
   chan_vec_type                    center_ch_ff;
   logic                            center_known_ff;
   logic [NCH-1:0][SUM_BITS-1:0]    sum_ff;
   logic [CNT_BITS-1:0]             cnt_ff;

   // Divider.
   logic [NCH-1:0][SUM_BITS-1:0]    quo_ff;
   logic [NCH-1:0][REM_BITS-1:0]    rem_ff;
   logic [DCNT_BITS-1:0]            div_cnt_ff;

   // Output register.
   logic         rsp_tvalid_ff;
   chan_vec_type rsp_ch_ff;
   logic         rsp_known_ff;
   logic         rsp_last_ff;
   logic         out_free;

   assign npix       = T_BITS'(w_ff) * T_BITS'(h_ff);
   assign last_t     = npix + T_BITS'(w_ff);
   assign in_image   = (t_ff < npix);
   assign px_last    = (px_ff == w_ff - 1'b1);
   assign py_last    = (py_ff == h_ff - 1'b1);
   assign pixel_last = px_last && py_last;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign status.has_result = (t_ff > T_BITS'(w_ff));
   assign status.div_last   = (div_cnt_ff == DCNT_BITS'(SUM_BITS - 1));
   assign status.out_free   = out_free;

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         in_ch[i] = CHANNEL_BITS'(req_tdata[i*mnad_pkg::PORT_CHAN_BITS +:
                                            mnad_pkg::PORT_CHAN_BITS]);
      end
      // Flush items enter the window as unknown zero pixels.
      cur_in_known = in_image && req_tuser;
      cur_in_ch    = in_image ? in_ch : '0;
   end

   // Configuration, frame position and output pixel counters.
   always_comb begin
      t_in      = t_ff;
      slot_t_in = slot_t_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      slot_p_in = slot_p_ff;
      if (cmd.accept) begin
         if (t_ff == last_t) begin
            t_in      = '0;
            slot_t_in = '0;
         end else begin
            t_in      = t_ff + 1'b1;
            slot_t_in = (slot_t_ff == S_BITS'(DEPTH - 1)) ? '0 : slot_t_ff + 1'b1;
         end
      end
      if (cmd.out_load) begin
         if (pixel_last) begin
            px_in     = '0;
            py_in     = '0;
            slot_p_in = '0;
         end else begin
            if (px_last) begin
               px_in = '0;
               py_in = py_ff + 1'b1;
            end else begin
               px_in = px_ff + 1'b1;
            end
            slot_p_in = (slot_p_ff == S_BITS'(DEPTH - 1)) ? '0 : slot_p_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff      <= W_BITS'(RESET_W);
         h_ff      <= H_BITS'(RESET_H);
         t_ff      <= '0;
         slot_t_ff <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         slot_p_ff <= '0;
      end else if (csr_write && (csr_addr == mnad_pkg::REG_IMAGE_WIDTH ||
                                 csr_addr == mnad_pkg::REG_IMAGE_HEIGHT)) begin
         // Zero acts as one and oversize values as the maximum.
         if (csr_addr == mnad_pkg::REG_IMAGE_WIDTH) begin
            if (csr_wdata == '0) begin
               w_ff <= W_BITS'(1);
            end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
               w_ff <= W_BITS'(MAX_WIDTH);
            end else begin
               w_ff <= W_BITS'(csr_wdata);
            end
         end else begin
            if (csr_wdata == '0) begin
               h_ff <= H_BITS'(1);
            end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
               h_ff <= H_BITS'(MAX_HEIGHT);
            end else begin
               h_ff <= H_BITS'(csr_wdata);
            end
         end
         t_ff      <= '0;
         slot_t_ff <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         slot_p_ff <= '0;
      end else begin
         t_ff      <= t_in;
         slot_t_ff <= slot_t_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
         slot_p_ff <= slot_p_in;
      end
   end

   // Tap geometry and ring address of the neighbour being read.
   always_comb begin
      row_up     = UPPER_TAPS[cmd.tap];
      row_down   = LOWER_TAPS[cmd.tap];
      col_left   = LEFT_TAPS[cmd.tap];
      col_right  = RIGHT_TAPS[cmd.tap];
      tap_inside = !(row_up && py_ff == '0) && !(row_down && py_last) &&
                   !(col_left && px_ff == '0) && !(col_right && px_last);
      if (row_up) begin
         row_off = -$signed(A_BITS'(w_ff));
      end else if (row_down) begin
         row_off = $signed(A_BITS'(w_ff));
      end else begin
         row_off = '0;
      end
      if (col_left) begin
         col_off = -$signed(A_BITS'(1));
      end else if (col_right) begin
         col_off = $signed(A_BITS'(1));
      end else begin
         col_off = '0;
      end
      addr_raw = $signed(A_BITS'(slot_p_ff)) + row_off + col_off;
      if (addr_raw < 0) begin
         addr_fix = addr_raw + DEPTH_S;
      end else if (addr_raw >= DEPTH_S) begin
         addr_fix = addr_raw - DEPTH_S;
      end else begin
         addr_fix = addr_raw;
      end
      rd_addr = addr_fix[S_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[slot_t_ff] <= {cur_in_known, cur_in_ch};
      end
      if (cmd.issue) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_known_ff <= cur_in_known;
         cur_ch_ff    <= cur_in_ch;
      end
      if (cmd.issue) begin
         acc_center_ff <= (cmd.tap == mnad_pkg::CENTER_TAP);
         acc_nb_ff     <= tap_inside && (cmd.tap != mnad_pkg::CENTER_TAP);
         acc_cur_ff    <= (cmd.tap == mnad_pkg::CURRENT_TAP);
      end
   end

   // The lower right neighbour is the item that has just arrived.
   always_comb begin
      if (acc_cur_ff) begin
         src_known = cur_known_ff;
         src_ch    = cur_ch_ff;
      end else begin
         src_known = rd_entry_ff[ENTRY_BITS-1];
         src_ch    = rd_entry_ff[ENTRY_BITS-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (acc_en_ff) begin
         if (acc_center_ff) begin
            center_known_ff <= src_known;
            center_ch_ff    <= src_ch;
         end
         if (acc_nb_ff && src_known) begin
            for (int i = 0; i < NCH; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_BITS'(src_ch[i]);
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Restoring division of all channels at once, one quotient bit a cycle.
   always_ff @(posedge clock) begin
      logic [REM_BITS:0] trial;
      logic              ge;
      if (cmd.div_load) begin
         for (int i = 0; i < NCH; i++) begin
            quo_ff[i] <= sum_ff[i] + SUM_BITS'(cnt_ff >> 1);
         end
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         for (int i = 0; i < NCH; i++) begin
            trial = {rem_ff[i], quo_ff[i][SUM_BITS-1]};
            ge    = (trial >= cnt_ff);
            rem_ff[i] <= ge ? REM_BITS'(trial - cnt_ff) : REM_BITS'(trial);
            quo_ff[i] <= {quo_ff[i][SUM_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_last_ff <= pixel_last;
         if (center_known_ff || cnt_ff == '0) begin
            rsp_known_ff <= center_known_ff;
            rsp_ch_ff    <= center_ch_ff;
         end else begin
            rsp_known_ff <= 1'b1;
            for (int i = 0; i < NCH; i++) begin
               rsp_ch_ff[i] <= quo_ff[i][CHANNEL_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         rsp_tdata[i*mnad_pkg::PORT_CHAN_BITS +: mnad_pkg::PORT_CHAN_BITS] =
            mnad_pkg::PORT_CHAN_BITS'(rsp_ch_ff[i]);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_known_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/masked_neighbor_average_dilation.sv */
// A pixel that yields a result steps through nine window reads through the single memory
// read port, a drain, the divider load, the one-bit-a-cycle divider and the output hand-off;
// no new item is taken until it is through, and the hand-off waits while the output is stalled.
// Warm-up items of a frame are accepted without window reads and yield no result.
// Reset clears the control state and sets both sizes to 1024 (capped at the maximum);
// the window memory is not cleared, as no pixel is read before it is written.
module masked_neighbor_average_dilation #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_HEIGHT   = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // in_red, in_green, in_blue, in_metallic, in_roughness
   input  logic [mnad_pkg::TDATA_BITS-1:0]    req_tdata,
   // in_known
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_red, out_green, out_blue, out_metallic, out_roughness
   output logic [mnad_pkg::TDATA_BITS-1:0]    rsp_tdata,
   // out_known
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mnad_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [mnad_pkg::CFG_BITS-1:0]      csr_wdata
);

   mnad_pkg::dp_cmd_type    cmd;
   mnad_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   mnad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mnad_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_write  (csr_valid && csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/mnad_checker.sv */
// Port-level checks of the dilation block and their binding to the top level.
module mnad_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mnad_pkg::TDATA_BITS-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A new result appears as the block finishes an item and is ready again.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("result beat appeared outside the end of an item");

   // The block only becomes busy on an accepted input beat.
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("input ready dropped without an accepted beat");

   // The window reads keep the block busy, so input ready does not return right after it falls.
   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |=> !req_tready)
      else $error("input ready returned too early");

endmodule

bind masked_neighbor_average_dilation mnad_checker u_mnad_checker (.*);
